// ===== rtl/amcs_pkg.sv =====
// Package of the adaptive music chunk sequencer: request codes, table sizes,
// the front-to-back command word and the state encoding. No dependencies.
package amcs_pkg;

  localparam int unsigned MaxChunks   = 256;
  localparam int unsigned MaxLinks    = 1024;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned ChunkIdxW   = $clog2(MaxChunks);
  localparam int unsigned LinkIdxW    = $clog2(MaxLinks);
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] KeyEnd   = 8'd64;
  localparam logic [7:0] KeyPrior = 8'd65;

  typedef enum logic [2:0] {
    REQ_LOAD_CHUNK = 3'd0,
    REQ_LOAD_TRIG  = 3'd1,
    REQ_LOAD_INTEN = 3'd2,
    REQ_SELECT     = 3'd3,
    REQ_CONSUME    = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    CMD_SELECT  = 2'd0,
    CMD_CONSUME = 2'd1
  } cmd_e;

  // Work word handed from the front part to the back part.
  typedef struct packed {
    cmd_e        op;
    logic [7:0]  trig;
    logic [7:0]  inten;
    logic [31:0] size;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE_RD,
    ST_RANGE_WAIT,
    ST_TRIG_RD,
    ST_TRIG_CHK,
    ST_INTEN_RD,
    ST_INTEN_CHK,
    ST_DECIDE,
    ST_BOUNDS_RD,
    ST_BOUNDS_WAIT,
    ST_SEGMENT,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/amcs_front.sv =====
// Front part: accepts words, performs table loads, queues select and consume work.
// Depends on amcs_pkg.
module amcs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            req_type_i,
  input  logic [9:0]            entry_index_i,
  input  logic [7:0]            link_key_i,
  input  logic [7:0]            wanted_intensity_i,
  input  logic [31:0]           byte_count_i,
  input  logic                  back_idle_i,
  output logic                  load_chunk_o,
  output logic                  load_trig_o,
  output logic                  load_inten_o,
  output logic                  cmd_valid_o,
  input  logic                  cmd_ready_i,
  output amcs_pkg::cmd_t        cmd_o
);
  import amcs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            fifo_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            accept, push, pop, is_load;
  cmd_t            new_cmd;

  // A load must not overtake queued or running work that still reads the tables,
  // so it is only taken once the queue is empty and the back part is idle.
  assign is_load    = (req_type_i == REQ_LOAD_CHUNK) || (req_type_i == REQ_LOAD_TRIG) ||
                      (req_type_i == REQ_LOAD_INTEN);
  assign in_ready_o = (count_q != (PtrW+1)'(QueueDepth)) &&
                      (!is_load || (count_q == '0 && back_idle_i));
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    load_chunk_o = 1'b0;
    load_trig_o  = 1'b0;
    load_inten_o = 1'b0;
    push         = 1'b0;
    new_cmd.op    = CMD_SELECT;
    new_cmd.trig  = link_key_i;
    new_cmd.inten = wanted_intensity_i;
    new_cmd.size  = byte_count_i;
    case (req_type_i)
      REQ_LOAD_CHUNK: load_chunk_o = accept && (entry_index_i < 10'(MaxChunks));
      REQ_LOAD_TRIG:  load_trig_o  = accept;
      REQ_LOAD_INTEN: load_inten_o = accept;
      REQ_SELECT:     push = accept;
      REQ_CONSUME: begin
        push       = accept;
        new_cmd.op = CMD_CONSUME;
      end
      default: ;
    endcase
  end

  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end
endmodule

// ===== rtl/amcs_back.sv =====
// Back part: holds the chunk and link tables, runs link scans and emits segments.
// Depends on amcs_pkg.
module amcs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [8:0]            chunks_used_i,
  input  logic                  load_chunk_i,
  input  logic                  load_trig_i,
  input  logic                  load_inten_i,
  input  logic [9:0]            entry_index_i,
  input  logic [31:0]           start_offset_i,
  input  logic [31:0]           end_offset_i,
  input  logic [9:0]            trigger_first_i,
  input  logic [7:0]            trigger_total_i,
  input  logic [9:0]            intensity_first_i,
  input  logic [7:0]            intensity_total_i,
  input  logic [7:0]            link_key_i,
  input  logic [7:0]            target_chunk_i,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  amcs_pkg::cmd_t        cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           seg_address_o,
  output logic [31:0]           seg_length_o,
  output logic [7:0]            chunk_now_o,
  output logic                  playing_o,
  output logic                  last_o
);
  import amcs_pkg::*;

  // Tables, each one write and one registered read port.
  logic [63:0] bounds_mem [MaxChunks];
  logic [35:0] ranges_mem [MaxChunks];
  logic [15:0] trig_mem   [MaxLinks];
  logic [15:0] inten_mem  [MaxLinks];

  logic [ChunkIdxW-1:0] chunk_raddr;
  logic [LinkIdxW-1:0]  link_raddr;
  logic [63:0] bounds_rd_q;
  logic [35:0] ranges_rd_q;
  logic [15:0] trig_rd_q, inten_rd_q;

  always_ff @(posedge clk_i) begin
    if (load_chunk_i) begin
      bounds_mem[entry_index_i[ChunkIdxW-1:0]] <= {end_offset_i, start_offset_i};
      ranges_mem[entry_index_i[ChunkIdxW-1:0]] <=
        {intensity_total_i, intensity_first_i, trigger_total_i, trigger_first_i};
    end
    if (load_trig_i)  trig_mem[entry_index_i[LinkIdxW-1:0]]  <= {target_chunk_i, link_key_i};
    if (load_inten_i) inten_mem[entry_index_i[LinkIdxW-1:0]] <= {target_chunk_i, link_key_i};
    bounds_rd_q <= bounds_mem[chunk_raddr];
    ranges_rd_q <= ranges_mem[chunk_raddr];
    trig_rd_q   <= trig_mem[link_raddr];
    inten_rd_q  <= inten_mem[link_raddr];
  end

  state_e state_q, state_d;
  logic        active_q, active_d;
  logic [7:0]  cur_q, cur_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  held_q, held_d;
  cmd_e        op_q, op_d;
  logic [7:0]  trig_q, trig_d, inten_q, inten_d;
  logic [31:0] size_q, size_d;
  logic [SegCntW-1:0] nseg_q, nseg_d;
  logic [LinkIdxW-1:0] base_q, base_d;
  logic [7:0]  k_q, k_d, total_q, total_d;
  logic [35:0] ranges_q, ranges_d;
  logic [8:0]  best_q, best_d;
  logic [7:0]  best_tgt_q, best_tgt_d;
  logic        ended_q, ended_d;
  logic [31:0] csize_q, csize_d, addr_q, addr_d, st_q, st_d;
  logic [31:0] seg_len_q, seg_len_d;
  logic        ov_q, ov_d;
  logic [31:0] oaddr_q, oaddr_d, olen_q, olen_d;
  logic [7:0]  ochunk_q, ochunk_d;
  logic        oplay_q, oplay_d, olast_q, olast_d;

  logic [7:0] key_w, dist_w;
  logic [31:0] remain_w, bytes_w, newpos_w;
  logic [8:0] seq_w;

  assign out_valid_o   = ov_q;
  assign seg_address_o = oaddr_q;
  assign seg_length_o  = olen_q;
  assign chunk_now_o   = ochunk_q;
  assign playing_o     = oplay_q;
  assign last_o        = olast_q;

  assign cmd_ready_o = (state_q == ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == CMD_SELECT) state_d = ST_RANGE_RD;
          else if (active_q && cmd_i.size != '0) state_d = ST_BOUNDS_RD;
          else state_d = ST_EMIT;
        end
      end
      ST_RANGE_RD:    state_d = ST_RANGE_WAIT;
      ST_RANGE_WAIT:  state_d = ST_TRIG_RD;
      ST_TRIG_RD:     state_d = (k_q == total_q) ? ST_INTEN_RD : ST_TRIG_CHK;
      ST_TRIG_CHK: begin
        if (trig_rd_q[7:0] == KeyEnd || trig_rd_q[7:0] == KeyPrior) state_d = ST_DECIDE;
        else if (op_q == CMD_SELECT && trig_rd_q[7:0] == trig_q) state_d = ST_DECIDE;
        else state_d = ST_TRIG_RD;
      end
      ST_INTEN_RD:    state_d = (k_q == total_q) ? ST_DECIDE : ST_INTEN_CHK;
      ST_INTEN_CHK:   state_d = ST_INTEN_RD;
      ST_DECIDE:      state_d = ST_EMIT;
      ST_BOUNDS_RD:   state_d = ST_BOUNDS_WAIT;
      ST_BOUNDS_WAIT: state_d = ST_SEGMENT;
      ST_SEGMENT:     state_d = (newpos_w >= csize_q) ? ST_RANGE_RD : ST_EMIT;
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          if (op_q == CMD_CONSUME && active_q && size_q != '0 &&
              nseg_q != SegCntW'(MaxSegments) && nseg_q != '0) state_d = ST_BOUNDS_RD;
          else state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign key_w    = (state_q == ST_INTEN_CHK) ? inten_rd_q[7:0] : trig_rd_q[7:0];
  assign dist_w   = (key_w >= inten_q) ? key_w - inten_q : inten_q - key_w;
  assign remain_w = (pos_q < csize_q) ? csize_q - pos_q : '0;
  assign bytes_w  = (remain_w < size_q) ? remain_w : size_q;
  assign newpos_w = pos_q + bytes_w;
  assign seq_w    = {1'b0, cur_q} + 9'd1;

  // Datapath and output logic.
  always_comb begin
    active_d = active_q; cur_d = cur_q; pos_d = pos_q; held_d = held_q;
    op_d = op_q; trig_d = trig_q; inten_d = inten_q; size_d = size_q; nseg_d = nseg_q;
    base_d = base_q; k_d = k_q; total_d = total_q; ranges_d = ranges_q;
    best_d = best_q; best_tgt_d = best_tgt_q; ended_d = ended_q;
    csize_d = csize_q; addr_d = addr_q; st_d = st_q; seg_len_d = seg_len_q;
    ov_d = ov_q; oaddr_d = oaddr_q; olen_d = olen_q; ochunk_d = ochunk_q;
    oplay_d = oplay_q; olast_d = olast_q;
    chunk_raddr = cur_q;
    link_raddr  = base_q + LinkIdxW'(k_q);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        op_d = cmd_i.op; trig_d = cmd_i.trig; size_d = cmd_i.size; nseg_d = '0;
        inten_d = (cmd_i.op == CMD_SELECT) ? cmd_i.inten : held_q;
      end
      ST_RANGE_RD: begin
        chunk_raddr = (op_q == CMD_SELECT) ? '0 : cur_q;
        ended_d = 1'b0; best_d = 9'd256; best_tgt_d = '0;
      end
      ST_RANGE_WAIT: begin
        ranges_d = ranges_rd_q;
        base_d  = ranges_rd_q[9:0];
        total_d = ranges_rd_q[17:10];
        k_d = '0;
      end
      ST_TRIG_RD: begin
        if (k_q == total_q) begin
          base_d = ranges_q[27:18]; total_d = ranges_q[35:28]; k_d = '0;
        end
      end
      ST_TRIG_CHK: begin
        k_d = k_q + 8'd1;
        if (key_w == KeyEnd || key_w == KeyPrior) ended_d = 1'b1;
        else if (op_q == CMD_SELECT && key_w == trig_q) begin
          // A trigger match is recorded as a best distance of zero.
          best_d = 9'd0; best_tgt_d = trig_rd_q[15:8];
        end
      end
      ST_INTEN_CHK: begin
        k_d = k_q + 8'd1;
        if ({1'b0, dist_w} < best_q) begin
          best_d = {1'b0, dist_w}; best_tgt_d = inten_rd_q[15:8];
        end
      end
      ST_DECIDE: begin
        if (op_q == CMD_SELECT) begin
          if (!ended_q) begin
            active_d = 1'b1; pos_d = '0; held_d = inten_q;
            cur_d = (best_q != 9'd256) ? best_tgt_q :
                    ((9'd1 >= chunks_used_i) ? 8'd0 : 8'd1);
          end
        end else begin
          if (ended_q) active_d = 1'b0;
          else cur_d = (best_q != 9'd256) ? best_tgt_q :
                       ((seq_w >= chunks_used_i) ? 8'd0 : seq_w[7:0]);
        end
      end
      ST_BOUNDS_WAIT: begin
        st_d    = bounds_rd_q[31:0];
        csize_d = bounds_rd_q[63:32] - bounds_rd_q[31:0];
      end
      ST_SEGMENT: begin
        addr_d    = st_q + pos_q;
        seg_len_d = bytes_w;
        size_d    = size_q - bytes_w;
        nseg_d    = nseg_q + SegCntW'(1);
        pos_d     = (newpos_w >= csize_q) ? '0 : newpos_w;
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          ochunk_d = cur_q; oplay_d = active_q;
          if (op_q == CMD_CONSUME && nseg_q != '0) begin
            oaddr_d = addr_q;
            olen_d  = seg_len_q;
            olast_d = !(active_q && size_q != '0 && nseg_q != SegCntW'(MaxSegments));
          end else begin
            oaddr_d = '0; olen_d = '0; olast_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      active_q <= 1'b0; cur_q <= '0; pos_q <= '0; held_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      active_q <= active_d; cur_q <= cur_d; pos_q <= pos_d; held_q <= held_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; trig_q <= trig_d; inten_q <= inten_d; size_q <= size_d;
    nseg_q <= nseg_d; base_q <= base_d; k_q <= k_d; total_q <= total_d;
    ranges_q <= ranges_d; best_q <= best_d; best_tgt_q <= best_tgt_d;
    ended_q <= ended_d; csize_q <= csize_d; addr_q <= addr_d;
    st_q <= st_d; seg_len_q <= seg_len_d; oaddr_q <= oaddr_d; olen_q <= olen_d;
    ochunk_q <= ochunk_d; oplay_q <= oplay_d; olast_q <= olast_d;
  end
endmodule

// ===== rtl/adaptive_music_chunk_sequencer.sv =====
// Top level of the adaptive music chunk sequencer: front part, back part, register.
// Depends on amcs_pkg, amcs_front and amcs_back.
//
// The sequencer accepts one word at a time on the in channel. Load words (chunk,
// trigger link, intensity link) are written into the tables in the cycle they are
// accepted and give no result; a load is only accepted once the queue is empty and
// the back part is idle, so that it never changes a table under earlier work.
// Select and consume words pass through a two-entry queue to the back part, which
// scans the chunk's trigger links and then its intensity links, each table entry
// in a read state and then a check state, to choose the next chunk. An end key, or
// for a select a trigger match, cuts the scan short. A consume reads the bounds of
// the chunk, cuts a segment and emits it, for each segment in turn, and scans the
// links again whenever a chunk ends. Results leave through an output register, so
// the back part only waits while that register is full. The chunk count is written
// through cfg_we_i / cfg_data_i; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module adaptive_music_chunk_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] start_offset_i,
  input  logic [31:0] end_offset_i,
  input  logic [9:0]  trigger_first_i,
  input  logic [7:0]  trigger_total_i,
  input  logic [9:0]  intensity_first_i,
  input  logic [7:0]  intensity_total_i,
  input  logic [7:0]  link_key_i,
  input  logic [7:0]  target_chunk_i,
  input  logic [7:0]  wanted_intensity_i,
  input  logic [31:0] byte_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] seg_address_o,
  output logic [31:0] seg_length_o,
  output logic [7:0]  chunk_now_o,
  output logic        playing_o,
  output logic        last_o
);
  import amcs_pkg::*;

  logic [8:0] chunks_used_q;
  logic       load_chunk, load_trig, load_inten, cmd_valid, cmd_ready;
  cmd_t       cmd;

  // The chunk count register resets to one chunk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunks_used_q <= 9'd1;
    end else if (cfg_we_i) begin
      chunks_used_q <= cfg_data_i;
    end
  end

  amcs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .entry_index_i,
    .link_key_i, .wanted_intensity_i, .byte_count_i, .back_idle_i (cmd_ready),
    .load_chunk_o (load_chunk), .load_trig_o (load_trig), .load_inten_o (load_inten),
    .cmd_valid_o  (cmd_valid),  .cmd_ready_i (cmd_ready), .cmd_o (cmd)
  );

  amcs_back u_back (
    .clk_i, .rst_ni, .chunks_used_i (chunks_used_q),
    .load_chunk_i (load_chunk), .load_trig_i (load_trig), .load_inten_i (load_inten),
    .entry_index_i, .start_offset_i, .end_offset_i, .trigger_first_i,
    .trigger_total_i, .intensity_first_i, .intensity_total_i, .link_key_i,
    .target_chunk_i, .cmd_valid_i (cmd_valid), .cmd_ready_o (cmd_ready), .cmd_i (cmd),
    .out_valid_o, .out_ready_i, .seg_address_o, .seg_length_o, .chunk_now_o,
    .playing_o, .last_o
  );
endmodule

// ===== rtl/amcs_checker.sv =====
// Port checker for the adaptive music chunk sequencer, bound to the top level.
// Depends on nothing but the top level's ports.
module amcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] seg_address_o,
  input logic [31:0] seg_length_o,
  input logic        playing_o,
  input logic        last_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(seg_address_o) &&
    $stable(seg_length_o) && $stable(playing_o) && $stable(last_o))
    else $error("result word dropped while stalled");
  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result word right after reset");
  a_notplay_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !playing_o |-> last_o)
    else $error("word after end of track not marked last");
endmodule

bind adaptive_music_chunk_sequencer amcs_checker u_amcs_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_music_chunk_sequencer: the tables are
// loaded, then selects and consumes are checked against a predictor kept here.
// Depends on amcs_pkg and the sequencer RTL.
module tb_top;
  import amcs_pkg::*;

  // One input word, every field held at its port width.
  typedef struct {
    logic [2:0]  kind;
    logic [9:0]  idx;
    logic [31:0] so;
    logic [31:0] eo;
    logic [9:0]  tfirst;
    logic [7:0]  ttotal;
    logic [9:0]  ifirst;
    logic [7:0]  itotal;
    logic [7:0]  key;
    logic [7:0]  tgt;
    logic [7:0]  inten;
    logic [31:0] nbytes;
  } word_t;

  // One segment result as it should appear on the out channel.
  typedef struct {
    logic [31:0] addr;
    logic [31:0] len;
    logic [7:0]  chunk;
    logic        play;
    logic        last;
  } seg_t;

  localparam int unsigned StallLimit = 40000;
  // Leading chunk and link entries that random words reference; directed words and some loads go beyond them.
  localparam int unsigned UsedChunks = 16;
  localparam int unsigned UsedLinks  = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [9:0]  entry_index_i = '0;
  logic [31:0] start_offset_i = '0;
  logic [31:0] end_offset_i = '0;
  logic [9:0]  trigger_first_i = '0;
  logic [7:0]  trigger_total_i = '0;
  logic [9:0]  intensity_first_i = '0;
  logic [7:0]  intensity_total_i = '0;
  logic [7:0]  link_key_i = '0;
  logic [7:0]  target_chunk_i = '0;
  logic [7:0]  wanted_intensity_i = '0;
  logic [31:0] byte_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] seg_address_o;
  logic [31:0] seg_length_o;
  logic [7:0]  chunk_now_o;
  logic        playing_o;
  logic        last_o;

  adaptive_music_chunk_sequencer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .entry_index_i     (entry_index_i),
    .start_offset_i    (start_offset_i),
    .end_offset_i      (end_offset_i),
    .trigger_first_i   (trigger_first_i),
    .trigger_total_i   (trigger_total_i),
    .intensity_first_i (intensity_first_i),
    .intensity_total_i (intensity_total_i),
    .link_key_i        (link_key_i),
    .target_chunk_i    (target_chunk_i),
    .wanted_intensity_i(wanted_intensity_i),
    .byte_count_i      (byte_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .seg_address_o     (seg_address_o),
    .seg_length_o      (seg_length_o),
    .chunk_now_o       (chunk_now_o),
    .playing_o         (playing_o),
    .last_o            (last_o)
  );

  // Words waiting to be offered, and segments the predictor says must come out.
  word_t pending_words[$];
  seg_t  due_segments[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned segments_seen = 0;

  // Mirror of the sequencer's tables and playback state.
  logic [31:0] bound_lo [MaxChunks];
  logic [31:0] bound_hi [MaxChunks];
  logic [9:0]  trig_first_m [MaxChunks];
  logic [7:0]  trig_total_m [MaxChunks];
  logic [9:0]  inten_first_m [MaxChunks];
  logic [7:0]  inten_total_m [MaxChunks];
  logic [7:0]  trig_key_m [MaxLinks];
  logic [7:0]  trig_tgt_m [MaxLinks];
  logic [7:0]  inten_key_m [MaxLinks];
  logic [7:0]  inten_tgt_m [MaxLinks];
  logic [8:0]  wrap_point = 9'd1;
  logic        is_playing = 1'b0;
  logic [7:0]  cur_chunk = '0;
  logic [31:0] play_pos = '0;
  logic [7:0]  held_level = '0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Picks the chunk that follows chunk idx. The trigger links come first: an
  // end key stops the track, a matching key jumps. Then the nearest intensity
  // link wins, the earliest on a tie; failing both, the next chunk in order.
  function automatic logic [7:0] next_chunk(input logic [7:0] idx, input bit has_trig,
                                            input logic [7:0] trig, input logic [7:0] level,
                                            output bit ended);
    int unsigned best;
    int unsigned gap;
    int unsigned nx;
    logic [9:0]  li;
    logic [7:0]  best_tgt;
    bit          found;
    best = 256;
    best_tgt = '0;
    found = 0;
    ended = 0;
    for (int k = 0; k < trig_total_m[idx]; k++) begin
      li = trig_first_m[idx] + k[9:0];
      if (trig_key_m[li] == KeyEnd || trig_key_m[li] == KeyPrior) begin
        ended = 1;
        return '0;
      end
      if (has_trig && trig_key_m[li] == trig) return trig_tgt_m[li];
    end
    for (int k = 0; k < inten_total_m[idx]; k++) begin
      li = inten_first_m[idx] + k[9:0];
      gap = (inten_key_m[li] >= level) ? inten_key_m[li] - level : level - inten_key_m[li];
      if (gap < best) begin
        best = gap;
        best_tgt = inten_tgt_m[li];
        found = 1;
      end
    end
    if (found) return best_tgt;
    nx = idx + 1;
    if (nx >= wrap_point) nx = 0;
    return nx[7:0];
  endfunction

  function automatic seg_t make_seg(input logic [31:0] addr, input logic [31:0] len,
                                    input logic last);
    seg_t s;
    s.addr = addr;
    s.len = len;
    s.chunk = cur_chunk;
    s.play = is_playing;
    s.last = last;
    return s;
  endfunction

  // Applies one accepted word to the mirror and queues the segments it causes.
  task automatic apply_word(input word_t w);
    logic [7:0]  nx;
    logic [31:0] left;
    logic [31:0] csize;
    logic [31:0] remain;
    logic [31:0] take;
    logic [31:0] addr;
    bit          ended;
    int          n;
    case (w.kind)
      REQ_LOAD_CHUNK: begin
        if (w.idx < MaxChunks) begin
          bound_lo[w.idx[7:0]] = w.so;
          bound_hi[w.idx[7:0]] = w.eo;
          trig_first_m[w.idx[7:0]] = w.tfirst;
          trig_total_m[w.idx[7:0]] = w.ttotal;
          inten_first_m[w.idx[7:0]] = w.ifirst;
          inten_total_m[w.idx[7:0]] = w.itotal;
        end
      end
      REQ_LOAD_TRIG: begin
        trig_key_m[w.idx] = w.key;
        trig_tgt_m[w.idx] = w.tgt;
      end
      REQ_LOAD_INTEN: begin
        inten_key_m[w.idx] = w.key;
        inten_tgt_m[w.idx] = w.tgt;
      end
      REQ_SELECT: begin
        nx = next_chunk(8'd0, 1, w.key, w.inten, ended);
        if (!ended) begin
          is_playing = 1'b1;
          cur_chunk = nx;
          play_pos = '0;
          held_level = w.inten;
        end
        due_segments.push_back(make_seg('0, '0, 1'b1));
      end
      REQ_CONSUME: begin
        left = w.nbytes;
        n = 0;
        while (is_playing && left != 0 && n < MaxSegments) begin
          csize = bound_hi[cur_chunk] - bound_lo[cur_chunk];
          remain = (play_pos < csize) ? csize - play_pos : '0;
          take = (remain < left) ? remain : left;
          addr = bound_lo[cur_chunk] + play_pos;
          left -= take;
          play_pos += take;
          if (play_pos >= csize) begin
            play_pos = '0;
            nx = next_chunk(cur_chunk, 0, 8'd0, held_level, ended);
            if (ended) is_playing = 1'b0;
            else cur_chunk = nx;
          end
          n++;
          due_segments.push_back(make_seg(addr, take, 1'b0));
        end
        if (n == 0) due_segments.push_back(make_seg('0, '0, 1'b1));
        else due_segments[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch in %s at %0t: got %0h, expected %0h", what, $realtime, got, want);
    mismatches++;
  endtask

  // Sender: a word is taken into the predictor at the edge where it is accepted,
  // and the next one is put on the port in the same step.
  word_t on_port;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) apply_word(on_port);
      if (!in_valid_i || in_ready_o) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = pending_words.pop_front();
          req_type_i <= on_port.kind;
          entry_index_i <= on_port.idx;
          start_offset_i <= on_port.so;
          end_offset_i <= on_port.eo;
          trigger_first_i <= on_port.tfirst;
          trigger_total_i <= on_port.ttotal;
          intensity_first_i <= on_port.ifirst;
          intensity_total_i <= on_port.itotal;
          link_key_i <= on_port.key;
          target_chunk_i <= on_port.tgt;
          wanted_intensity_i <= on_port.inten;
          byte_count_i <= on_port.nbytes;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver with one long hold-off, counted here, once 40 segments have come,
  // so that the internal queue fills and the in channel stalls.
  int unsigned hold_left = 0;
  bit          hold_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        segments_seen++;
        if (due_segments.size() == 0) begin
          report("unexpected word", seg_address_o, '0);
        end else begin
          seg_t want;
          want = due_segments.pop_front();
          if (seg_address_o !== want.addr) report("seg_address", seg_address_o, want.addr);
          if (seg_length_o !== want.len) report("seg_length", seg_length_o, want.len);
          if (chunk_now_o !== want.chunk) report("chunk_now", chunk_now_o, want.chunk);
          if (playing_o !== want.play) report("playing", playing_o, want.play);
          if (last_o !== want.last) report("last", last_o, want.last);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!hold_done && segments_seen >= 40) begin
        hold_done = 1;
        hold_left = 400;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic word_t blank_word(input logic [2:0] kind);
    word_t w;
    w = '{default: '0};
    w.kind = kind;
    return w;
  endfunction

  function automatic word_t chunk_word(input logic [9:0] idx, input logic [31:0] so,
                                       input logic [31:0] len, input logic [9:0] tf,
                                       input logic [7:0] tt, input logic [9:0] inf,
                                       input logic [7:0] it);
    word_t w;
    w = blank_word(REQ_LOAD_CHUNK);
    w.idx = idx;
    w.so = so;
    w.eo = so + len;
    w.tfirst = tf;
    w.ttotal = tt;
    w.ifirst = inf;
    w.itotal = it;
    return w;
  endfunction

  function automatic word_t link_word(input logic [2:0] kind, input logic [9:0] idx,
                                      input logic [7:0] key, input logic [7:0] tgt);
    word_t w;
    w = blank_word(kind);
    w.idx = idx;
    w.key = key;
    w.tgt = tgt;
    return w;
  endfunction

  function automatic word_t play_word(input logic [2:0] kind, input logic [7:0] key,
                                      input logic [7:0] level, input logic [31:0] nbytes);
    word_t w;
    w = blank_word(kind);
    w.key = key;
    w.inten = level;
    w.nbytes = nbytes;
    return w;
  endfunction

  // Mostly small keys so that selects find their trigger; now and then any key,
  // which also lets the end keys appear.
  function automatic logic [7:0] pick_key();
    return ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));
  endfunction

  // A random word with every field filled, then shaped to its request type.
  // Link lists and targets stay inside the loaded entries.
  function automatic word_t random_word();
    word_t w;
    int unsigned pick;
    w.so = $urandom;
    w.eo = $urandom;
    w.tfirst = 10'($urandom_range(UsedLinks - 5));
    w.ttotal = 8'($urandom_range(4));
    w.ifirst = 10'($urandom_range(UsedLinks - 5));
    w.itotal = 8'($urandom_range(4));
    w.key = pick_key();
    w.tgt = 8'($urandom_range(UsedChunks - 1));
    w.inten = 8'($urandom);
    w.nbytes = $urandom_range(120);
    w.idx = 10'($urandom_range(UsedLinks - 1));
    pick = $urandom_range(99);
    if (pick < 18) begin
      w.kind = REQ_LOAD_CHUNK;
      w.idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(UsedChunks - 1));
      if ($urandom_range(4) != 0) w.eo = w.so + $urandom_range(60);
      // Now and then a chunk whose lists cover all the leading link entries, for long scans.
      if ($urandom_range(7) == 0) begin
        w.tfirst = '0;
        w.ttotal = 8'(UsedLinks);
        w.ifirst = '0;
        w.itotal = 8'(UsedLinks);
      end
    end else if (pick < 28) begin
      w.kind = REQ_LOAD_TRIG;
    end else if (pick < 38) begin
      w.kind = REQ_LOAD_INTEN;
      w.key = 8'($urandom);
    end else if (pick < 58) begin
      w.kind = REQ_SELECT;
    end else if (pick < 95) begin
      w.kind = REQ_CONSUME;
      if ($urandom_range(9) == 0) w.nbytes = $urandom;
      else if ($urandom_range(14) == 0) w.nbytes = '0;
    end else begin
      w.kind = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  task automatic drain();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || due_segments.size() != 0);
    // Loads give no result, so let any trailing work settle.
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_wrap(input logic [8:0] value);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wrap_point = value;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_wrap(9'd1);

    // Fill the chunk and link entries in use first, so that no later read finds
    // an unwritten one.
    for (int i = 0; i < UsedChunks; i++)
      pending_words.push_back(chunk_word(10'(i), $urandom, $urandom_range(1, 48),
                                         10'($urandom_range(UsedLinks - 4)),
                                         8'($urandom_range(3)),
                                         10'($urandom_range(UsedLinks - 4)),
                                         8'($urandom_range(3))));
    for (int i = 0; i < UsedLinks; i++) begin
      pending_words.push_back(link_word(REQ_LOAD_TRIG, 10'(i), pick_key(),
                                        8'($urandom_range(UsedChunks - 1))));
      pending_words.push_back(link_word(REQ_LOAD_INTEN, 10'(i), 8'($urandom),
                                        8'($urandom_range(UsedChunks - 1))));
    end

    send_idle_pct = 29;
    recv_idle_pct = 59;

    // Directed words. Consume while nothing plays, with and without bytes.
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'd0));
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'hFFFF_FFFF));
    // Chunk 0 leads by a trigger at the last link entry; an end key there stops
    // the select and keeps the state, for both end keys.
    pending_words.push_back(link_word(REQ_LOAD_TRIG, 10'd1023, KeyEnd, 8'd7));
    pending_words.push_back(chunk_word(10'd0, 32'd0, 32'd16, 10'd1023, 8'd2, 10'd0,
                                       8'd0));
    pending_words.push_back(play_word(REQ_SELECT, 8'd9, 8'd0, 32'd0));
    pending_words.push_back(link_word(REQ_LOAD_TRIG, 10'd1023, KeyPrior, 8'd7));
    pending_words.push_back(play_word(REQ_SELECT, 8'd9, 8'd255, 32'd0));
    // A trigger list that wraps past the table end and then matches.
    pending_words.push_back(link_word(REQ_LOAD_TRIG, 10'd1023, 8'd3, 8'd5));
    pending_words.push_back(link_word(REQ_LOAD_TRIG, 10'd0, 8'd9, 8'd7));
    // Intensity links at 10 and 20, used below with level 15: a tie, the first wins.
    pending_words.push_back(link_word(REQ_LOAD_INTEN, 10'd1010, 8'd10, 8'd3));
    pending_words.push_back(link_word(REQ_LOAD_INTEN, 10'd1011, 8'd20, 8'd4));
    pending_words.push_back(chunk_word(10'd7, 32'hFFFF_FFFA, 32'd10, 10'd0, 8'd0,
                                       10'd1010, 8'd2));
    pending_words.push_back(play_word(REQ_SELECT, 8'd9, 8'd15, 32'd0));
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'd3));
    // Shrinking the chunk being played leaves its position stale.
    pending_words.push_back(chunk_word(10'd7, 32'hFFFF_FFFA, 32'd2, 10'd0, 8'd0,
                                       10'd1010, 8'd2));
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'd5));
    // The intensity tie again, reached by a select from chunk 0.
    pending_words.push_back(chunk_word(10'd0, 32'd0, 32'd16, 10'd0, 8'd0, 10'd1010,
                                       8'd2));
    pending_words.push_back(play_word(REQ_SELECT, 8'd200, 8'd15, 32'd0));
    // Extreme offsets, an ignored chunk load and an unknown request type.
    pending_words.push_back(chunk_word(10'd3, 32'hFFFF_FFFF, 32'd0, 10'h3FF, 8'd0,
                                       10'h3FF, 8'd0));
    pending_words.push_back(chunk_word(10'd1023, 32'h1234_5678, 32'd9, 10'd0, 8'd255,
                                       10'd0, 8'd255));
    pending_words.push_back(play_word(3'd7, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'd0));
    pending_words.push_back(play_word(REQ_CONSUME, 8'd0, 8'd0, 32'hFFFF_FFFF));
    for (int i = 0; i < 45; i++) pending_words.push_back(random_word());
    drain();

    write_wrap(9'(UsedChunks));
    send_idle_pct = 59;
    recv_idle_pct = 29;
    for (int i = 0; i < 45; i++) pending_words.push_back(random_word());
    drain();

    write_wrap(9'($urandom_range(2, UsedChunks)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 37; i++) pending_words.push_back(random_word());
    drain();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
